FILE: hw/rtl/isrd_pkg.sv
// shared constants, tap tables and microcode program for the reflection delay block
`timescale 1ns / 1ps

package isrd_pkg;

   // sample and register widths
   localparam int SAMPLE_W    = 24;
   localparam int ROOM_W      = 15;
   localparam int INV_W       = 17;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 17;

   // sample store, power-of-two depth so delays wrap by masking
   localparam int STORE_DEPTH = 65536;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // taps: direct path plus four first-order wall images
   localparam int TAP_COUNT   = 5;
   localparam int TAP_W       = $clog2(TAP_COUNT);
   localparam int DLY_W       = 24;
   localparam int RCP_W       = 17;
   localparam int DLY_SHIFT   = 24;
   localparam int RCP_SHIFT   = 16;
   localparam int DLY_PROD_W  = ROOM_W + DLY_W;
   localparam int RCP_PROD_W  = INV_W + RCP_W;
   localparam int GAIN_W      = RCP_PROD_W - RCP_SHIFT;
   localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
   localparam int ACC_W       = PROD_W + 3;
   localparam int WET_SHIFT   = 17;

   // register reset values
   localparam logic [ROOM_W-1:0] ROOM_RESET = ROOM_W'(2560);
   localparam logic [INV_W-1:0]  INV_RESET  = INV_W'(6554);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROOM_SIZE         = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_ROOM_SIZE = CSR_IDX_W'(1);

   // microcode
   localparam int STEP_W = 4;

   typedef enum logic [1:0] {
      JMP_NEVER,
      JMP_NO_ITEM,
      JMP_OUT_BUSY
   } jump_cond_type;

   typedef struct packed {
      logic [TAP_W-1:0]  calc_tap;
      logic              take;
      logic              rd;
      logic              mul;
      logic              acc_clr;
      logic              acc_en;
      logic              wr;
      logic              out;
      jump_cond_type     jump_cond;
      logic [STEP_W-1:0] jump_to;
      logic [STEP_W-1:0] next_step;
   } ucode_type;

   // delay in samples per metre, Q16
   function automatic logic [DLY_W-1:0] tap_delay(input logic [TAP_W-1:0] tap);
      logic [DLY_W-1:0] v;
      case (tap)
         TAP_W'(0): v = DLY_W'(7602993);
         TAP_W'(1): v = DLY_W'(9617110);
         TAP_W'(2): v = DLY_W'(12259458);
         TAP_W'(3): v = DLY_W'(10752256);
         TAP_W'(4): v = DLY_W'(7602993);
         default:   v = '0;
      endcase
      return v;
   endfunction

   // reciprocal of the path factor, Q16
   function automatic logic [RCP_W-1:0] tap_recip(input logic [TAP_W-1:0] tap);
      logic [RCP_W-1:0] v;
      case (tap)
         TAP_W'(0): v = RCP_W'(73271);
         TAP_W'(1): v = RCP_W'(57926);
         TAP_W'(2): v = RCP_W'(45441);
         TAP_W'(3): v = RCP_W'(51811);
         TAP_W'(4): v = RCP_W'(73271);
         default:   v = '0;
      endcase
      return v;
   endfunction

   // program: tap i is set up at step i, read at i+1, multiplied at i+2, summed at i+3
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '0;
      w.jump_cond = JMP_NEVER;
      w.next_step = step + STEP_W'(1);
      case (step)
         STEP_W'(0): begin
            w.calc_tap  = TAP_W'(0);
            w.take      = 1'b1;
            w.jump_cond = JMP_NO_ITEM;
            w.jump_to   = STEP_W'(0);
         end
         STEP_W'(1): begin
            w.calc_tap = TAP_W'(1);
            w.rd       = 1'b1;
         end
         STEP_W'(2): begin
            w.calc_tap = TAP_W'(2);
            w.rd       = 1'b1;
            w.mul      = 1'b1;
         end
         STEP_W'(3): begin
            w.calc_tap = TAP_W'(3);
            w.rd       = 1'b1;
            w.mul      = 1'b1;
            w.acc_clr  = 1'b1;
            w.acc_en   = 1'b1;
         end
         STEP_W'(4): begin
            w.calc_tap = TAP_W'(4);
            w.rd       = 1'b1;
            w.mul      = 1'b1;
            w.acc_en   = 1'b1;
         end
         STEP_W'(5): begin
            w.rd     = 1'b1;
            w.mul    = 1'b1;
            w.acc_en = 1'b1;
         end
         STEP_W'(6): begin
            w.mul    = 1'b1;
            w.acc_en = 1'b1;
            w.wr     = 1'b1;
         end
         STEP_W'(7): begin
            w.acc_en = 1'b1;
         end
         STEP_W'(8): begin
            w.out       = 1'b1;
            w.jump_cond = JMP_OUT_BUSY;
            w.jump_to   = STEP_W'(8);
            w.next_step = STEP_W'(0);
         end
         default: begin
            w.next_step = STEP_W'(0);
         end
      endcase
      return w;
   endfunction

endpackage

FILE: hw/rtl/isrd_if.sv
// valid/ready channel interfaces for samples and register writes
`timescale 1ns / 1ps

interface isrd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [isrd_pkg::SAMPLE_W-1:0]  in_sample;

   modport source (output valid, output in_sample, input ready);
   modport sink (input valid, input in_sample, output ready);
endinterface

interface isrd_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [isrd_pkg::SAMPLE_W-1:0]  out_sample;

   modport source (output valid, output out_sample, input ready);
   modport sink (input valid, input out_sample, output ready);
endinterface

interface isrd_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [isrd_pkg::CSR_IDX_W-1:0]        index;
   logic [isrd_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/isrd_ram.sv
// generic single-clock ram, one write and one registered read port
`timescale 1ns / 1ps

module isrd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hw/rtl/image_source_reflection_delay_top.sv
// image-source early reflection delay: five-tap ring store with microcoded control
`timescale 1ns / 1ps
//
// Usage:
//   req carries one signed Q1.23 dry sample per item; rsp returns one signed
//   Q1.23 sample per item: dry plus half of the five weighted taps, saturated.
//   csr writes room_size (index 0, Q7.8) and inverse_room_size (index 1,
//   Q1.16); csr is always ready and must only be used while the block is idle.
//   The result is loaded into the output register at the last program step.
//   The microcode program runs five tap reads and one write through the single
//   sample ram per item and takes a new item only after the previous one.
//   When rsp stalls, the result holds in the output register; the next item
//   is still taken and worked on, and the program waits at its last step
//   until the output register is free.
//   Reset: registers return to room 10 m, stored samples read as zero; entries
//   not written since reset are masked by a fill pointer plus a wrap flag, so
//   there is no clearing pass and the block is ready in the cycle after reset.

module image_source_reflection_delay_top (
   input  logic       clock,
   input  logic       reset,
   isrd_req_if.sink   req,
   isrd_rsp_if.source rsp,
   isrd_csr_if.sink   csr
);

   import isrd_pkg::*;

   localparam int WETQ_W = ACC_W - WET_SHIFT;
   localparam int SUM_W  = WETQ_W + 1;
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(2 ** (SAMPLE_W - 1));

   // control state
   logic [STEP_W-1:0]              step_ff, step_in;
   logic [ROOM_W-1:0]              room_size_ff, room_size_in;
   logic [INV_W-1:0]               inv_room_ff, inv_room_in;
   logic [ADDR_W-1:0]              wr_pos_ff, wr_pos_in;
   logic                           full_ff, full_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [ADDR_W-1:0]              back_ff, back_in;
   logic [GAIN_W-1:0]              gain_ff, gain_in;
   logic [GAIN_W-1:0]              gain_d_ff, gain_d_in;
   logic                           hit_ff, hit_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0]     dry_ff, dry_in;
   logic signed [SAMPLE_W-1:0]     rsp_sample_ff, rsp_sample_in;

   ucode_type                      uc;
   logic                           out_busy;
   logic                           jump;
   logic                           accept;
   logic                           out_fire;
   logic [DLY_PROD_W-1:0]          delay_prod;
   logic [RCP_PROD_W-1:0]          gain_prod;
   logic [ADDR_W-1:0]              rd_addr;
   logic [SAMPLE_W-1:0]            rd_data;
   logic signed [SAMPLE_W-1:0]     tap_sample;
   logic signed [GAIN_W:0]         gain_s;
   logic signed [WETQ_W-1:0]       wet_q;
   logic signed [SUM_W-1:0]        sum;
   logic signed [SAMPLE_W-1:0]     sat;

   // sequencer
   assign uc       = ucode_rom(step_ff);
   assign out_busy = rsp_valid_ff && !rsp.ready;
   assign jump     = ((uc.jump_cond == JMP_NO_ITEM) && !req.valid) ||
                     ((uc.jump_cond == JMP_OUT_BUSY) && out_busy);
   assign step_in  = jump ? uc.jump_to : uc.next_step;
   assign accept   = uc.take && req.valid;
   assign out_fire = uc.out && !out_busy;

   // handshakes
   assign req.ready      = uc.take;
   assign csr.ready      = 1'b1;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_sample = rsp_sample_ff;

   // register writes
   always_comb begin
      room_size_in = room_size_ff;
      inv_room_in  = inv_room_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_ROOM_SIZE:         room_size_in = csr.data[ROOM_W-1:0];
            CSR_INVERSE_ROOM_SIZE: inv_room_in  = csr.data[INV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // tap setup: delay and gain from the room registers
   assign delay_prod = DLY_PROD_W'(room_size_ff) * DLY_PROD_W'(tap_delay(uc.calc_tap));
   assign gain_prod  = RCP_PROD_W'(inv_room_ff) * RCP_PROD_W'(tap_recip(uc.calc_tap));
   assign back_in    = ADDR_W'(delay_prod >> DLY_SHIFT);
   assign gain_in    = GAIN_W'(gain_prod >> RCP_SHIFT);

   // tap read: entries past the fill pointer before the first wrap read as zero
   assign rd_addr   = wr_pos_ff - back_ff;
   assign hit_in    = full_ff || (rd_addr < wr_pos_ff);
   assign gain_d_in = gain_ff;

   // weight the tap
   assign tap_sample = hit_ff ? signed'(rd_data) : '0;
   assign gain_s     = signed'({1'b0, gain_d_ff});
   assign prod_in    = PROD_W'(tap_sample) * PROD_W'(gain_s);

   // accumulate
   assign acc_in = uc.acc_clr ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);

   // dry plus half the wet sum, floor and saturate
   assign wet_q = signed'(acc_ff[ACC_W-1:WET_SHIFT]);
   assign sum   = SUM_W'(dry_ff) + SUM_W'(wet_q);
   assign sat   = (sum > SUM_MAX) ? SAMPLE_W'(SUM_MAX) :
                  (sum < SUM_MIN) ? SAMPLE_W'(SUM_MIN) : sum[SAMPLE_W-1:0];

   assign dry_in        = accept ? req.in_sample : dry_ff;
   assign rsp_sample_in = out_fire ? sat : rsp_sample_ff;

   // write pointer and output valid
   assign wr_pos_in    = out_fire ? wr_pos_ff + ADDR_W'(1) : wr_pos_ff;
   assign full_in      = full_ff || (out_fire && (wr_pos_ff == '1));
   assign rsp_valid_in = out_fire ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         room_size_ff <= ROOM_RESET;
         inv_room_ff  <= INV_RESET;
         wr_pos_ff    <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         room_size_ff <= room_size_in;
         inv_room_ff  <= inv_room_in;
         wr_pos_ff    <= wr_pos_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      back_ff       <= back_in;
      gain_ff       <= gain_in;
      dry_ff        <= dry_in;
      rsp_sample_ff <= rsp_sample_in;
      if (uc.rd) begin
         hit_ff    <= hit_in;
         gain_d_ff <= gain_d_in;
      end
      if (uc.mul) begin
         prod_ff <= prod_in;
      end
      if (uc.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   // sample store
   isrd_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (uc.wr),
      .wr_addr (wr_pos_ff),
      .wr_data (dry_ff),
      .rd_en   (uc.rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

FILE: hw/rtl/isrd_checker.sv
// port-level checks for the reflection delay top, bound to it
`timescale 1ns / 1ps

module isrd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [isrd_pkg::SAMPLE_W-1:0]    rsp_out_sample,
   input logic                             csr_ready
);

   import isrd_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_sample))
      else $error("stalled result changed");

   // one item at a time: no second item in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted back to back");

   // a new result appears only from the last program step, never while taking items
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared outside the output step");

   // after reset the block is empty and waiting for an item
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready && csr_ready)
      else $error("bad state after reset");

endmodule

bind image_source_reflection_delay_top isrd_checker u_isrd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_out_sample (rsp.out_sample),
   .csr_ready      (csr.ready)
);

FILE: tb/tb.sv
// self-checking testbench for the image-source reflection delay block
`timescale 1ns / 1ps

module tb;
   import isrd_pkg::*;

   typedef logic signed [SAMPLE_W-1:0] sample_t;

   localparam longint SAMPLE_HI = 64'sd8388607;
   localparam longint SAMPLE_LO = -64'sd8388608;

   // expected output samples, computed from a private copy of the ring store and registers
   class reflection_scoreboard;
      sample_t           history [STORE_DEPTH];
      logic [ADDR_W-1:0] head;
      logic [ROOM_W-1:0] room;
      logic [INV_W-1:0]  inv_room;
      sample_t           expected_q [$];
      int                errors;

      function new();
         foreach (history[i]) history[i] = '0;
         head     = '0;
         room     = ROOM_W'(2560);
         inv_room = INV_W'(6554);
         errors   = 0;
      endfunction

      // samples per metre as Q16 for each path
      function longint delay_per_metre(int unsigned tap);
         case (tap)
            0, 4:    return 64'd7602993;
            1:       return 64'd9617110;
            2:       return 64'd12259458;
            default: return 64'd10752256;
         endcase
      endfunction

      // reciprocal path factor as Q16 for each path
      function longint recip_factor(int unsigned tap);
         case (tap)
            0, 4:    return 64'd73271;
            1:       return 64'd57926;
            2:       return 64'd45441;
            default: return 64'd51811;
         endcase
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_ROOM_SIZE:         room = value[ROOM_W-1:0];
            CSR_INVERSE_ROOM_SIZE: inv_room = value[INV_W-1:0];
            default: ;
         endcase
      endfunction

      // one dry sample in: sum the five taps, store the sample, queue the result
      function void note_input(sample_t dry);
         longint            wet;
         longint            lag;
         longint            gain;
         longint            mixed;
         logic [ADDR_W-1:0] pos;
         wet = 0;
         for (int unsigned t = 0; t < TAP_COUNT; t++) begin
            lag  = (longint'(room) * delay_per_metre(t)) >>> 24;
            gain = (longint'(inv_room) * recip_factor(t)) >>> 16;
            pos  = head - lag[ADDR_W-1:0];
            wet += longint'(history[pos]) * gain;
         end
         history[head] = dry;
         head = head + 1'b1;
         mixed = longint'(dry) + (wet >>> WET_SHIFT);
         if (mixed > SAMPLE_HI) mixed = SAMPLE_HI;
         if (mixed < SAMPLE_LO) mixed = SAMPLE_LO;
         expected_q.push_back(sample_t'(mixed));
      endfunction

      function void check_output(sample_t got);
         sample_t want;
         if (expected_q.size() == 0) begin
            $error("out_sample with no item pending: expected none, actual %0d", got);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               $error("out_sample mismatch: expected %0d, actual %0d", want, got);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;

   isrd_req_if req_ch ();
   isrd_rsp_if rsp_ch ();
   isrd_csr_if csr_ch ();

   reflection_scoreboard tracker = new();

   image_source_reflection_delay_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // run limit
   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

   // result side: random back-pressure and checking of each accepted item
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         tracker.check_output(rsp_ch.out_sample);
   end

   // send one item after a random gap; valid stays high so items can go back to back
   task automatic push_sample(input sample_t value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.in_sample <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.note_input(value);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      tracker.set_register(idx, value);
   endtask

   // wait until every result is back, then set both registers
   task automatic set_room(input logic [ROOM_W-1:0] room, input logic [INV_W-1:0] inv);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      write_register(CSR_ROOM_SIZE, CSR_DATA_W'(room));
      write_register(CSR_INVERSE_ROOM_SIZE, CSR_DATA_W'(inv));
      csr_ch.valid <= 1'b0;
   endtask

   // stimulus
   initial begin
      int                total;
      int                count;
      int                mode;
      int                pick;
      logic [ROOM_W-1:0] room;
      logic [INV_W-1:0]  inv;
      sample_t           value;

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.in_sample <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= '0;
      csr_ch.data      <= '0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // field extremes and bit patterns at the reset room (taps still empty)
      push_sample(sample_t'(SAMPLE_HI));
      push_sample(sample_t'(SAMPLE_LO));
      push_sample('0);
      push_sample('1);
      push_sample(sample_t'(1));
      push_sample(sample_t'(24'h555555));
      push_sample(sample_t'(24'haaaaaa));

      // zero delay: every tap reads the entry about to be overwritten
      set_room('0, INV_W'(65536));
      push_sample(sample_t'(SAMPLE_HI));
      push_sample(sample_t'(-24'sd12345));
      push_sample(sample_t'(24'sd777777));
      push_sample(sample_t'(SAMPLE_LO));

      // tiny room with the largest gain: short taps that saturate both ways
      set_room(ROOM_W'(3), '1);
      repeat (6) push_sample(sample_t'(SAMPLE_HI));
      repeat (6) push_sample(sample_t'(SAMPLE_LO));

      // random phases, each with its own room and idle pattern
      total = 0;
      mode  = 0;
      while (total < 700) begin
         pick = $urandom_range(99);
         if (pick < 65)
            room = ROOM_W'($urandom_range(200, 2));
         else if (pick < 85) begin
            case ($urandom_range(3))
               0:       room = ROOM_W'(256);
               1:       room = ROOM_W'(25600);
               2:       room = '0;
               default: room = '1;
            endcase
         end else
            room = ROOM_W'($urandom());

         pick = $urandom_range(99);
         if (pick < 60)
            inv = (room == 0) ? '1 : INV_W'(((32'd1 << 24) / room > 131071) ?
                                            131071 : (32'd1 << 24) / room);
         else if (pick < 80)
            inv = ($urandom_range(1) == 0) ? '0 : '1;
         else
            inv = INV_W'($urandom());

         set_room(room, inv);

         case (mode % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         mode++;

         count = $urandom_range(80, 40);
         for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 70)
               value = sample_t'($urandom());
            else if (pick < 85)
               value = sample_t'($signed($urandom_range(2000)) - 1000);
            else
               value = ($urandom_range(1) == 0) ? sample_t'(SAMPLE_HI) : sample_t'(SAMPLE_LO);
            push_sample(value);
         end
         total += count;
      end

      // drain and let the pipeline settle
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (tracker.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/isrd_pkg.sv
hw/rtl/isrd_if.sv
hw/rtl/isrd_ram.sv
hw/rtl/image_source_reflection_delay_top.sv
hw/rtl/isrd_checker.sv
tb/tb.sv
